// File: rtl/psfr_pkg.sv
// Package for the packed sensor frame receiver.
// Frame constants, divider reciprocals and the gas level decode; no dependencies.
package psfr_pkg;

  localparam logic [7:0] FrameHeader = 8'h84;
  localparam int         FrameLen    = 7;
  localparam int         CntW        = 3;
  localparam logic [CntW-1:0] LastIdx = CntW'(FrameLen - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(FrameLen);

  // speed: word*100/1955, estimate via floor(2^24/1955) = 8581, one-step fixup
  localparam int         SpdShift = 24;
  localparam logic [19:0] SpdRecip = 20'd858100;  // 100 * 8581
  localparam logic [22:0] SpdMul   = 23'd100;
  localparam logic [22:0] SpdDiv   = 23'd1955;

  // battery: (b+4)*5115/1000, estimate via floor(2^21/1000) = 2097
  localparam int          BatShift = 21;
  localparam logic [23:0] BatRecip = 24'd10726155; // 5115 * 2097
  localparam logic [20:0] BatMul   = 21'd5115;
  localparam logic [20:0] BatDiv   = 21'd1000;
  localparam logic [8:0]  BatOfs   = 9'd4;

  typedef logic [6:0] sbyte_t;

  function automatic logic [6:0] gas_decode(input logic [7:0] d0);
    logic [6:0] lvl;
    lvl = 7'd0;
    for (int b = 0; b < 3; b++) begin
      if (d0[b]) lvl = lvl + 7'd25;
    end
    if (lvl == 7'd0 && d0[4]) lvl = 7'd10;
    return lvl;
  endfunction

endpackage

// File: rtl/packed_sensor_frame_receiver.sv
// Packed sensor frame receiver: serial byte framing, 7-to-8 bit repacking and
// sensor value decode. Depends on psfr_pkg.
//
// Takes one byte per cycle with no stall of its own, unless out_ready holds
// results back. A byte with bit 7 set is a header; others are data bytes.
// After header 0x84 and seven data bytes, one item with gas level, engine
// speed, gas temperature and battery voltage leaves through three registered
// stages (frame capture, repack and reciprocal multiply, remainder fixup). The
// stages stall only when out_ready holds results back.
module packed_sensor_frame_receiver
  import psfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  gas_level,
  output logic [11:0] engine_speed_code,
  output logic [7:0]  gas_temperature,
  output logic [10:0] battery_volt_code
);

  logic [7:0]      header_code, header_code_next;
  logic [CntW-1:0] byte_count, byte_count_next;
  sbyte_t          frame_bytes [FrameLen];
  logic            in_fire, store_en, frame_done;

  logic            frame_vld;
  sbyte_t          frame_raw [FrameLen];

  logic            calc_vld;
  logic [6:0]      calc_lvl;
  logic [7:0]      calc_temp;
  logic [15:0]     calc_word;
  logic [11:0]     calc_spd_q;
  logic [8:0]      calc_bat_x;
  logic [10:0]     calc_bat_q;

  logic            out_load, calc_ready, frame_ready;

  assign out_load    = calc_vld && (!out_valid || out_ready);
  assign calc_ready  = !calc_vld || out_load;
  assign frame_ready = !frame_vld || calc_ready;
  assign in_ready    = frame_ready;
  assign in_fire     = in_valid && in_ready;

  // framing
  always_comb begin
    header_code_next = header_code;
    byte_count_next  = byte_count;
    store_en         = 1'b0;
    frame_done       = 1'b0;
    if (rx_byte[7]) begin
      if (header_code[7] && byte_count > CntW'(1)) begin
        byte_count_next = '0;
        frame_done      = (header_code == FrameHeader) && (byte_count == FullCnt);
      end
      header_code_next = rx_byte;
    end else if (byte_count < FullCnt) begin
      store_en = 1'b1;
      if (header_code[7] && byte_count == LastIdx) begin
        byte_count_next = '0;
        frame_done      = (header_code == FrameHeader);
      end else begin
        byte_count_next = byte_count + CntW'(1);
      end
    end else begin
      byte_count_next  = '0;
      header_code_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_code <= '0;
      byte_count  <= '0;
    end else if (in_fire) begin
      header_code <= header_code_next;
      byte_count  <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && store_en) frame_bytes[byte_count] <= rx_byte[6:0];
  end

  // stage 1: capture the whole frame
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_vld <= 1'b0;
    end else if (frame_ready) begin
      frame_vld <= in_fire && frame_done;
    end
  end

  // a header closes a frame already held in full
  always_ff @(posedge clk) begin
    if (frame_ready && in_fire && frame_done) begin
      for (int i = 0; i < FrameLen - 1; i++) frame_raw[i] <= frame_bytes[i];
      frame_raw[FrameLen-1] <= rx_byte[7] ? frame_bytes[FrameLen-1] : rx_byte[6:0];
    end
  end

  // stage 2: repack, decode, reciprocal estimates
  logic [7:0]  d0, d1, d2, d3, d5;
  logic [15:0] word;
  logic [8:0]  bat_x;
  logic [35:0] spd_prod;
  logic [31:0] bat_prod;

  assign d0       = {frame_raw[0][5:0], frame_raw[1][6:5]};
  assign d1       = {frame_raw[1][4:0], frame_raw[2][6:4]};
  assign d2       = {frame_raw[2][3:0], frame_raw[3][6:3]};
  assign d3       = {frame_raw[3][2:0], frame_raw[4][6:2]};
  assign d5       = {frame_raw[5][0],   frame_raw[6][6:0]};
  assign word     = {d1, d2};
  assign bat_x    = {1'b0, d5} + BatOfs;
  assign spd_prod = 36'(word) * 36'(SpdRecip);
  assign bat_prod = 32'(bat_x) * 32'(BatRecip);

  always_ff @(posedge clk) begin
    if (rst) begin
      calc_vld <= 1'b0;
    end else if (calc_ready) begin
      calc_vld <= frame_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_ready && frame_vld) begin
      calc_lvl   <= gas_decode(d0);
      calc_temp  <= d3;
      calc_word  <= word;
      calc_spd_q <= spd_prod[SpdShift+11:SpdShift];
      calc_bat_x <= bat_x;
      calc_bat_q <= bat_prod[BatShift+10:BatShift];
    end
  end

  // stage 3: the estimates are low by at most one
  logic [22:0] spd_rem;
  logic [20:0] bat_rem;

  assign spd_rem = 23'(calc_word) * SpdMul - 23'(calc_spd_q) * SpdDiv;
  assign bat_rem = 21'(calc_bat_x) * BatMul - 21'(calc_bat_q) * BatDiv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= calc_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      gas_level         <= calc_lvl;
      gas_temperature   <= calc_temp;
      engine_speed_code <= calc_spd_q + 12'(spd_rem >= SpdDiv);
      battery_volt_code <= calc_bat_q + 11'(bat_rem >= BatDiv);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(engine_speed_code) && $stable(battery_volt_code))
    else $error("result changed while stalled");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    in_fire && !rx_byte[7] && byte_count < LastIdx |=>
      byte_count == $past(byte_count) + CntW'(1))
    else $error("data byte did not advance count");

  a_frame_captured: assert property (@(posedge clk) disable iff (rst)
    in_fire && frame_done |=> frame_vld)
    else $error("completed frame not captured");

  a_out_from_calc: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(calc_vld))
    else $error("result without calc stage");

endmodule

// File: dv/packed_sensor_frame_receiver_tb.sv
// Testbench for packed_sensor_frame_receiver: byte stream driver, frame decode
// predictor and result scoreboard in one top module. Depends on psfr_pkg.
module packed_sensor_frame_receiver_tb;
  import psfr_pkg::*;

  typedef struct {
    logic [6:0]  gas;
    logic [11:0] speed;
    logic [7:0]  temp;
    logic [10:0] volt;
  } reading_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [6:0]  gas_level;
  logic [11:0] engine_speed_code;
  logic [7:0]  gas_temperature;
  logic [10:0] battery_volt_code;

  packed_sensor_frame_receiver dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .rx_byte           (rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .gas_level         (gas_level),
    .engine_speed_code (engine_speed_code),
    .gas_temperature   (gas_temperature),
    .battery_volt_code (battery_volt_code)
  );

  // predictor state
  logic [7:0] hdr_held;
  logic [2:0] count_held;
  logic [6:0] held_bytes [FrameLen];

  reading_t   expected_readings [$];
  logic [8:0] pending_bytes [$];  // bit 8 marks a drain point
  logic [8:0] next_entry;
  int         n_items;
  int         n_fail;
  logic       in_fire;
  logic       drain_hold;
  int         burst_left;
  int         gap_left;
  int         stall_mode;
  int         stall_per;
  int         stall_phase;
  int         stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] repack_byte(int i);
    logic [15:0] hi;
    logic [15:0] lo;
    hi = 16'(held_bytes[i]) << (i + 2);
    lo = (16'(held_bytes[i + 1]) >> (5 - i)) & ((16'd1 << (i + 2)) - 16'd1);
    return hi[7:0] | lo[7:0];
  endfunction

  task automatic close_held_frame();
    reading_t   r;
    logic [7:0] d0;
    logic [7:0] d3;
    logic [7:0] d5;
    int unsigned word;
    if (hdr_held == FrameHeader) begin
      if (count_held < 3'(FrameLen)) begin
        hdr_held = 8'h00;
      end else begin
        d0 = repack_byte(0);
        d3 = repack_byte(3);
        d5 = repack_byte(5);
        word = {repack_byte(1), repack_byte(2)};
        r.gas = 7'd0;
        for (int b = 0; b < 3; b++) begin
          if (d0[b]) r.gas = r.gas + 7'd25;
        end
        if (d0[4] && r.gas == 7'd0) r.gas = 7'd10;
        r.speed = 12'((word * 100) / 1955);
        r.temp  = d3;
        r.volt  = 11'(((int'(d5) + 4) * 5115) / 1000);
        expected_readings.push_back(r);
      end
    end
    count_held = 3'd0;
  endtask

  task automatic predict_byte(input logic [7:0] b);
    if (b[7]) begin
      if (hdr_held[7] && count_held > 3'd1) close_held_frame();
      hdr_held = b;
    end else if (count_held < 3'(FrameLen)) begin
      held_bytes[count_held] = b[6:0];
      count_held = count_held + 3'd1;
      if (hdr_held[7] && count_held == 3'(FrameLen)) close_held_frame();
    end else begin
      count_held = 3'd0;
      hdr_held   = 8'h00;
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back({1'b0, b});
    n_items++;
  endtask

  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'h7F;
      default: return 8'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic push_frame(input bit with_header);
    if (with_header) push_byte(FrameHeader);
    for (int k = 0; k < FrameLen; k++) push_byte(rand_data());
  endtask

  // input side: bursts with random gaps, drain points hold until scoreboard is empty
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (drain_hold) begin
        if (expected_readings.size() == 0) drain_hold = 1'b0;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_bytes[0][8]) begin
        next_entry = pending_bytes.pop_front();
        drain_hold = 1'b1;
        in_valid <= 1'b0;
      end else begin
        next_entry = pending_bytes.pop_front();
        rx_byte  <= next_entry[7:0];
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // output side stall pattern
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_per  = $urandom_range(2, 12);
      stall_left = $urandom_range(20, 80);
    end else begin
      stall_left--;
    end
    stall_phase++;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= (stall_phase % stall_per) != 0;
      2:       out_ready <= $urandom_range(0, 1);
      default: out_ready <= (stall_phase % stall_per) >= stall_per - 2;
    endcase
  end

  // accept inputs into the predictor, check results against the scoreboard
  always @(posedge clk) begin
    reading_t r;
    in_fire = in_valid && in_ready && !rst;
    if (in_fire) predict_byte(rx_byte);
    if (!rst && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t unexpected item: gas %0d speed %0d temp %0d volt %0d", $time,
                 gas_level, engine_speed_code, gas_temperature, battery_volt_code);
        n_fail++;
      end else begin
        r = expected_readings.pop_front();
        if (gas_level !== r.gas) begin
          $display("%0t gas_level expected %0d actual %0d", $time, r.gas, gas_level);
          n_fail++;
        end
        if (engine_speed_code !== r.speed) begin
          $display("%0t engine_speed_code expected %0d actual %0d", $time, r.speed,
                   engine_speed_code);
          n_fail++;
        end
        if (gas_temperature !== r.temp) begin
          $display("%0t gas_temperature expected %0d actual %0d", $time, r.temp,
                   gas_temperature);
          n_fail++;
        end
        if (battery_volt_code !== r.volt) begin
          $display("%0t battery_volt_code expected %0d actual %0d", $time, r.volt,
                   battery_volt_code);
          n_fail++;
        end
      end
    end
  end

  initial begin
    int kind;
    int n_data;
    bit mid_drain;
    rst         = 1'b1;
    in_valid    = 1'b0;
    rx_byte     = 8'h00;
    out_ready   = 1'b0;
    in_fire     = 1'b0;
    drain_hold  = 1'b0;
    burst_left  = 0;
    gap_left    = 0;
    stall_left  = 0;
    stall_phase = 0;
    stall_mode  = 0;
    stall_per   = 2;
    hdr_held    = 8'h00;
    count_held  = 3'd0;
    n_items     = 0;
    n_fail      = 0;
    mid_drain   = 1'b0;
    for (int k = 0; k < FrameLen; k++) held_bytes[k] = 7'd0;

    // no header: seven bytes held, the eighth clears everything
    for (int k = 0; k < FrameLen; k++) push_byte((k % 2) ? 8'h7F : 8'h00);
    push_byte(8'h55);
    // seven bytes held with no header, then two headers: the second closes them
    for (int k = 0; k < FrameLen; k++) push_byte(8'h30 | 8'(k));
    push_byte(FrameHeader);
    push_byte(FrameHeader);
    // one byte held before the header is kept as the first frame byte
    push_byte(8'h04);
    push_byte(FrameHeader);
    for (int k = 0; k < FrameLen - 1; k++) push_byte(8'h1F);
    // header stays after a result: seven more data bytes form the next frame
    for (int k = 0; k < FrameLen; k++) push_byte(8'h7F);
    // short frame closed by another header
    push_byte(FrameHeader);
    push_byte(8'h00);
    push_byte(8'h7F);
    push_byte(8'hFF);
    pending_bytes.push_back(9'h100);

    while (n_items < 530) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        push_frame($urandom_range(0, 9) != 0);
      end else if (kind < 78) begin
        push_byte(8'h80 | 8'($urandom_range(0, 127)));
        n_data = $urandom_range(0, 8);
        for (int k = 0; k < n_data; k++) push_byte(rand_data());
      end else if (kind < 90) begin
        push_byte(FrameHeader);
        n_data = $urandom_range(0, 6);
        for (int k = 0; k < n_data; k++) push_byte(rand_data());
      end else begin
        n_data = $urandom_range(1, 5);
        for (int k = 0; k < n_data; k++) push_byte(8'($urandom_range(0, 255)));
      end
      if (!mid_drain && n_items > 280) begin
        pending_bytes.push_back(9'h100);
        mid_drain = 1'b1;
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_bytes.size() != 0 || in_valid || drain_hold ||
           expected_readings.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_fail == 0 && expected_readings.size() == 0) begin
      $display("PASS packed_sensor_frame_receiver");
    end else begin
      $display("FAIL packed_sensor_frame_receiver");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL packed_sensor_frame_receiver");
    $finish;
  end

endmodule
